// File: src/dcsc_pkg.sv
// Shared types and constants of the dark-cell stencil counter.
// Used by dcsc_cell, the top level and the testbench; depends on nothing.
`default_nettype none
package dcsc_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned CFG_W        = 8;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned COUNT_W      = 14;
  localparam int unsigned MAX_SIDE_DEF = 128;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 14'd16383;
  localparam logic [CFG_W-1:0]   SIDE_RESET = 8'd128;
  localparam logic [CFG_W-1:0]   THR_RESET  = 8'd50;
  localparam logic [CFG_W-1:0]   SIDE_MIN   = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIDE    = 1'b0,
    CFG_DIP_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] dn;
  } column_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

endpackage
`default_nettype wire

// File: src/dcsc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package needed.
`default_nettype none
module dcsc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: src/dcsc_cell.sv
// One window cell: holds a three-pixel column and passes it to its neighbour.
// Depends on dcsc_pkg for the column type.
`default_nettype none
module dcsc_cell
  import dcsc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    shift_i,
  input  wire column_t col_i,
  output column_t      col_o
);

  column_t col_q, col_d;

  always_comb begin
    col_d = col_q;
    if (shift_i) begin
      col_d = col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule
`default_nettype wire

// File: src/dark_cell_stencil_counter.sv
// Dark-cell stencil counter, top level: position counters, line RAM, window cells.
// Depends on dcsc_pkg, dcsc_ram and dcsc_cell.
//
// Takes one pixel per clock in raster order and counts interior pixels that lie at
// least dip_threshold below all four orthogonal neighbours; one count request leaves
// per frame after its last pixel, via stage one and the output register. Throughput is one
// pixel per cycle, set by the single read and single write of the line RAM per
// column; the input stalls only while a finished count waits behind a stalled output.
// The two previous rows share one RAM of MAX_SIDE words, each holding a column's
// upper and middle pixel; it needs no clearing after reset. Configure only when idle.
`default_nettype none
module dark_cell_stencil_counter
  import dcsc_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [PIX_W-1:0]     pixel_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [COUNT_W-1:0]   abnormal_count_o
);

  localparam int unsigned COL_W  = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;

  logic [CFG_W-1:0]   side_cfg_q, thr_q;
  logic [COL_W-1:0]   col_q, col_d, row_q, row_d;
  logic [CMP_W-1:0]   side_ext;
  logic [SIDE_W-1:0]  side_eff;
  logic               last_col, last_row, accept;

  logic               s1_valid_q, s1_test_q, s1_last_q, s1_adv;
  logic [PIX_W-1:0]   s1_pix_q;
  logic [COL_W-1:0]   s1_col_q;

  line_pair_t         rd_pair, wr_pair;
  column_t            col_in, cell0, cell1;
  logic               hit;
  logic [COUNT_W-1:0] count_q, count_d, count_inc;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cfg_q <= SIDE_RESET;
      thr_q      <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_SIDE:    side_cfg_q <= cfg_data_i;
        CFG_DIP_THRESHOLD: thr_q      <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  always_comb begin
    side_ext = CMP_W'(side_cfg_q);
    if (side_ext < CMP_W'(SIDE_MIN)) begin
      side_ext = CMP_W'(SIDE_MIN);
    end
    if (side_ext > CMP_W'(MAX_SIDE)) begin
      side_ext = CMP_W'(MAX_SIDE);
    end
    side_eff = SIDE_W'(side_ext);
  end

  // position counters
  assign s1_adv     = s1_valid_q && !(s1_last_q && out_valid_o && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign last_col = (SIDE_W'(col_q) + SIDE_W'(1)) >= side_eff;
  assign last_row = (SIDE_W'(row_q) + SIDE_W'(1)) >= side_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + COL_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage one request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_q;
      s1_test_q <= (row_q >= COL_W'(2)) && (col_q >= COL_W'(2));
      s1_last_q <= last_col && last_row;
    end
  end

  // line RAM: read the column on accept, rotate it in stage one
  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1_pix_q;

  dcsc_ram #(
    .WIDTH ($bits(line_pair_t)),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (wr_pair),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_pair)
  );

  // window cells
  assign col_in.up  = rd_pair.upper;
  assign col_in.mid = rd_pair.middle;
  assign col_in.dn  = s1_pix_q;

  dcsc_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (col_in),
    .col_o   (cell0)
  );

  dcsc_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (cell0),
    .col_o   (cell1)
  );

  function automatic logic is_dip(logic [PIX_W-1:0] ctr, logic [PIX_W-1:0] thr,
                                  logic [PIX_W-1:0] nb);
    return ({1'b0, ctr} + {1'b0, thr}) <= {1'b0, nb};
  endfunction

  assign hit = s1_test_q
            && is_dip(cell0.mid, thr_q, cell0.up)
            && is_dip(cell0.mid, thr_q, cell0.dn)
            && is_dip(cell0.mid, thr_q, cell1.mid)
            && is_dip(cell0.mid, thr_q, rd_pair.middle);

  // count and result
  assign count_inc = (hit && (count_q != COUNT_MAX)) ? count_q + COUNT_W'(1) : count_q;

  always_comb begin
    count_d = count_q;
    if (s1_adv) begin
      count_d = s1_last_q ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      abnormal_count_o <= count_inc;
    end
  end

endmodule
`default_nettype wire

// File: tb/dcsc_count_checker.sv
`timescale 1ns / 100ps
// Count checker of the dark-cell stencil counter: watches config writes and both request
// channels, predicts each frame's abnormal count and compares it with the block's result.
// Depends on dcsc_pkg only.
module dcsc_count_checker
  import dcsc_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire logic [PIX_W-1:0]     pixel_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire logic [COUNT_W-1:0]   abnormal_count_i,
  output int                        errors_o,
  output int                        pending_o
);

  localparam int unsigned COL_W = $clog2(MAX_SIDE);

  logic [PIX_W-1:0]   upper_mem  [MAX_SIDE];
  logic [PIX_W-1:0]   middle_mem [MAX_SIDE];
  logic [PIX_W-1:0]   tap_up, tap_ctr, tap_left, tap_dn, tap_up_nx, tap_right;
  int unsigned        col_pos, row_pos;
  logic [COUNT_W-1:0] dark_cnt;
  logic [CFG_W-1:0]   side_reg, thr_reg;
  logic [COUNT_W-1:0] frame_counts_q [$];
  logic [COUNT_W-1:0] want;

  function automatic bit dips_below(logic [PIX_W-1:0] ctr, logic [PIX_W-1:0] nb);
    return (int'(ctr) + int'(thr_reg)) <= int'(nb);
  endfunction

  task automatic advance_window(input logic [PIX_W-1:0] pix);
    int unsigned side, c;
    side = 32'(side_reg);
    if (side < SIDE_MIN) side = 32'(SIDE_MIN);
    if (side > MAX_SIDE) side = MAX_SIDE;
    c = col_pos;
    if (c >= MAX_SIDE) c = MAX_SIDE - 1;
    tap_up_nx = upper_mem[c[COL_W-1:0]];
    tap_right = middle_mem[c[COL_W-1:0]];
    if (row_pos >= 2 && c >= 2 && dips_below(tap_ctr, tap_up) && dips_below(tap_ctr, tap_dn) &&
        dips_below(tap_ctr, tap_left) && dips_below(tap_ctr, tap_right) &&
        dark_cnt < COUNT_MAX) begin
      dark_cnt++;
    end
    tap_left      = tap_ctr;
    tap_ctr       = tap_right;
    tap_up        = tap_up_nx;
    tap_dn        = pix;
    upper_mem[c[COL_W-1:0]]  = middle_mem[c[COL_W-1:0]];
    middle_mem[c[COL_W-1:0]] = pix;
    if (c + 1 >= side) begin
      col_pos = 0;
      if (row_pos + 1 >= side) begin
        frame_counts_q.push_back(dark_cnt);
        dark_cnt = '0;
        row_pos  = 0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SIDE; i++) begin
        upper_mem[i[COL_W-1:0]]  = '0;
        middle_mem[i[COL_W-1:0]] = '0;
      end
      tap_up    = '0;
      tap_ctr   = '0;
      tap_left  = '0;
      tap_dn    = '0;
      tap_up_nx = '0;
      tap_right = '0;
      col_pos   = 0;
      row_pos   = 0;
      dark_cnt  = '0;
      side_reg  = SIDE_RESET;
      thr_reg   = THR_RESET;
      frame_counts_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_IMAGE_SIDE:    side_reg = cfg_data_i;
          CFG_DIP_THRESHOLD: thr_reg  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) advance_window(pixel_i);
      if (out_valid_i && !out_stall_i) begin
        if (frame_counts_q.size() == 0) begin
          $error("abnormal_count: expected none, actual %0d", abnormal_count_i);
          errors_o++;
        end else begin
          want = frame_counts_q.pop_front();
          if (abnormal_count_i !== want) begin
            $error("abnormal_count: expected %0d, actual %0d", want, abnormal_count_i);
            errors_o++;
          end
        end
      end
      pending_o = frame_counts_q.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the dark-cell stencil counter testbench: clock, reset, config writes and pixel
// frames under varying idling, and the verdict. Depends on dcsc_pkg, the block and
// dcsc_count_checker.
module tb;
  import dcsc_pkg::*;

  localparam int unsigned LIMIT       = 800000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_PIXELS = 1550;
  localparam int unsigned SETTLE      = 8;

  typedef enum int {PIX_UNIFORM, PIX_BIMODAL, PIX_CHECKER, PIX_FLAT} pix_mode_e;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = CFG_IMAGE_SIDE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [COUNT_W-1:0]   abnormal_count;

  int send_idle_pct = 24;
  int recv_idle_pct = 76;
  int hold_reqs     = 0;
  int hold_done     = 0;
  int errors, pending;
  int cycle_cnt;

  dark_cell_stencil_counter #(.MAX_SIDE(MAX_SIDE_DEF)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .pixel_i          (pixel),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .abnormal_count_o (abnormal_count)
  );

  dcsc_count_checker #(.MAX_SIDE(MAX_SIDE_DEF)) u_count_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .pixel_i          (pixel),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .abnormal_count_i (abnormal_count),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PIX_W-1:0] pick_pixel(pix_mode_e mode, int r, int c,
                                                   logic [PIX_W-1:0] base);
    logic [PIX_W-1:0] lo, hi;
    lo = PIX_W'($urandom_range(0, 90));
    hi = PIX_W'($urandom_range(160, 255));
    case (mode)
      PIX_UNIFORM: return PIX_W'($urandom_range(0, 255));
      PIX_BIMODAL: return $urandom_range(0, 1) ? hi : lo;
      PIX_CHECKER: return ((r + c) % 2) ? hi : lo;
      default:     return base + PIX_W'($urandom_range(0, 2));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    pixel    = pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input int side, input pix_mode_e mode);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom);
    for (int r = 0; r < side; r++)
      for (int c = 0; c < side; c++)
        send_pixel(pick_pixel(mode, r, c, base));
  endtask

  task automatic send_list(input logic [9*PIX_W-1:0] px);
    for (int i = 0; i < 9; i++) send_pixel(px[PIX_W*(8-i) +: PIX_W]);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] side, input logic [CFG_W-1:0] thr);
    drain();
    write_cfg(CFG_IMAGE_SIDE, side);
    write_cfg(CFG_DIP_THRESHOLD, thr);
  endtask

  // receiver: random stall, or a long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_done != hold_reqs) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** dark_cell_stencil_counter: FAILED **");
    $finish;
  end

  initial begin
    int               r, side_eff, nframes, rand_pixels;
    logic [CFG_W-1:0] side_val, thr_val;
    bit               hold_due;
    rand_pixels = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    set_config(8'd0, 8'd255);
    send_list({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
    set_config(8'd1, 8'd0);
    send_list('0);
    set_config(8'd2, 8'd50);
    send_list({8'd255, 8'd255, 8'd255, 8'd255, 8'd205, 8'd254, 8'd255, 8'd255, 8'd255});

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 76;
        recv_idle_pct = 24;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      hold_due = (ph != 1);
      while (rand_pixels < RAND_PIXELS * (ph + 1) / 3) begin
        r = $urandom_range(0, 99);
        if (r < 8)       side_val = CFG_W'($urandom_range(0, 2));
        else if (r < 75) side_val = CFG_W'($urandom_range(3, 8));
        else if (r < 95) side_val = CFG_W'($urandom_range(9, 16));
        else             side_val = CFG_W'($urandom_range(17, 40));
        r = $urandom_range(0, 99);
        if (r < 15)      thr_val = 8'd0;
        else if (r < 25) thr_val = 8'd255;
        else if (r < 45) thr_val = CFG_W'($urandom_range(0, 12));
        else             thr_val = CFG_W'($urandom_range(0, 255));
        if (hold_due) side_val = CFG_W'($urandom_range(3, 8));
        set_config(side_val, thr_val);
        side_eff = (side_val < SIDE_MIN) ? SIDE_MIN : side_val;
        nframes  = $urandom_range(1, 4);
        if (hold_due) begin
          hold_reqs++;
          hold_due = 1'b0;
          nframes  = 4;
        end
        repeat (nframes) begin
          send_frame(side_eff, pix_mode_e'($urandom_range(0, 3)));
          rand_pixels += side_eff * side_eff;
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("** dark_cell_stencil_counter: PASSED **");
    end else begin
      $display("** dark_cell_stencil_counter: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
src/dcsc_pkg.sv
src/dcsc_ram.sv
src/dcsc_cell.sv
src/dark_cell_stencil_counter.sv
tb/dcsc_count_checker.sv
tb/tb.sv
